/* hdl/incremental_pid_position_compensator_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros for the incremental pid position compensator
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_POSITION_COMPENSATOR_MACROS_SVH
`define INCREMENTAL_PID_POSITION_COMPENSATOR_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define IPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ipc assertion failed");

// consequent checked in the same cycle as the antecedent
`define IPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ipc assertion failed");

`endif

/* hdl/ipc_pkg.sv */
// ----------------------------------------------------------------------------
// ipc_pkg
// types, constants and helpers of the incremental pid position compensator
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

  typedef enum logic [1:0] {
    OP_PID   = 2'd0,
    OP_COMP  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_KP = 2'd0,
    CFG_KI = 2'd1,
    CFG_KD = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_P_MI,
    ST_P_MP,
    ST_P_MD,
    ST_P_DSC,
    ST_P_DADD,
    ST_P_WAIT,
    ST_P_SAT,
    ST_C_BAND,
    ST_C_MUL,
    ST_C_UPD,
    ST_EMIT
  } state_e;

  // accumulator limits in a 64-bit working width
  localparam logic signed [63:0] ACC_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN64 = 64'shFFFF_8000_0000_0000;
  localparam logic signed [47:0] ACC_MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN48 = 48'sh8000_0000_0000;

  // derivative product clip, +-2^52
  localparam logic signed [63:0] KD_LIM_P = 64'sh0010_0000_0000_0000;
  localparam logic signed [63:0] KD_LIM_N = 64'shFFF0_0000_0000_0000;

  // compensation bands and the q16.16 value of 0.4
  localparam logic signed [32:0] FAR_BAND       = 33'sd1200;
  localparam logic signed [32:0] NEAR_BAND      = 33'sd35;
  localparam logic signed [31:0] POINT_FOUR_Q16 = 32'sd26214;

  // divide by 250 (1 / 0.004), one byte digit per step
  localparam logic [7:0]  DIV_BASE   = 8'd250;
  localparam logic [16:0] DIV_RECIP  = 17'd67109;   // ceil(2^24 / 250)
  localparam int unsigned DIV_SHIFT  = 24;
  localparam int unsigned DIV_DIGITS = 8;

  typedef struct packed {
    logic               busy;
    logic signed [63:0] quot;
  } cdiv_st_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > ACC_MAX64) begin
      r = ACC_MAX48;
    end else if (v < ACC_MIN64) begin
      r = ACC_MIN48;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  // q32.16 to integer, truncated toward zero
  function automatic logic signed [31:0] acc_out(input logic signed [47:0] a);
    logic signed [31:0] q;
    q = a[47:16];
    if (a[47] && (a[15:0] != 16'd0)) begin
      q = q + 32'sd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

/* hdl/ipc_if.sv */
// ----------------------------------------------------------------------------
// ipc_if
// valid/ready channels of the compensator: command beats in, result beats out
// ----------------------------------------------------------------------------
`default_nettype none

interface ipc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [27:0] target_position;
  logic signed [27:0] sensed_position;
  logic signed [31:0] motor_encoder;

  modport source (
    output valid, operation, target_position, sensed_position, motor_encoder,
    input  ready
  );
  modport sink (
    input  valid, operation, target_position, sensed_position, motor_encoder,
    output ready
  );
endinterface

interface ipc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive_position;

  modport source (
    output valid, drive_position,
    input  ready
  );
  modport sink (
    input  valid, drive_position,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/ipc_mul.sv */
// ----------------------------------------------------------------------------
// ipc_mul
// shared signed 32x32 multiplier with a registered product
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_mul (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic signed [63:0]      p_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* hdl/ipc_cdiv.sv */
// ----------------------------------------------------------------------------
// ipc_cdiv
// signed divide by 250, truncated toward zero, one byte digit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_cdiv import ipc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] dividend_i,
  output cdiv_st_t                stat_o
);

  localparam int unsigned CNT_W = $clog2(DIV_DIGITS);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic [63:0]      num_q, num_d;
  logic [7:0]       rem_q, rem_d;
  logic [63:0]      quo_q, quo_d;

  logic [15:0] digit;
  logic [32:0] prod;
  logic [7:0]  qd;
  logic [15:0] qmul;
  logic [63:0] mag;
  logic signed [63:0] quo_s;

  // remainder below 250 keeps each partial dividend under 2^16
  assign digit = {rem_q, num_q[63:56]};
  assign prod  = {17'd0, digit} * {16'd0, DIV_RECIP};
  assign qd    = prod[DIV_SHIFT+7:DIV_SHIFT];
  assign qmul  = {8'd0, qd} * {8'd0, DIV_BASE};
  assign mag   = dividend_i[63] ? (~dividend_i + 64'd1) : dividend_i;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[63];
      num_d  = mag;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[55:0], 8'd0};
      rem_d = 8'(digit - qmul);
      quo_d = {quo_q[55:0], qd};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_DIGITS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_s       = $signed(quo_q);
  assign stat_o.busy = busy_q;
  assign stat_o.quot = neg_q ? -quo_s : quo_s;

endmodule

`default_nettype wire

/* hdl/incremental_pid_position_compensator.sv */
// ----------------------------------------------------------------------------
// incremental_pid_position_compensator
// velocity-form pid position loop with a position compensation mode
// ----------------------------------------------------------------------------
// Each command beat carries one operation and yields exactly one result beat
// on drive_position. The block handles one command at a time and lowers
// in_i.ready from acceptance until the result is placed in the output
// register; that register then waits for out_o.ready while the next command
// is already accepted. A pid step (operation 0) waits for the byte-serial
// divide by 250 of the integral product (eight digit steps), which runs
// beside the shared 32x32 multiplier; the multiplier forms the integral,
// proportional and derivative products in turn. A compensation step
// (operation 1) takes a shorter path on the first one after reset. Gains
// are to be written through the cfg port only while idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pid_position_compensator import ipc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  ipc_in_if.sink           in_i,
  ipc_out_if.source        out_o
);

  // sequencer
  state_e state_q, state_d;

  // gains, q16.16
  logic signed [31:0] kp_q, kp_d;
  logic signed [31:0] ki_q, ki_d;
  logic signed [31:0] kd_q, kd_d;

  // loop state
  logic signed [31:0] e1_q, e1_d;
  logic signed [31:0] e2_q, e2_d;
  logic signed [47:0] acc_q, acc_d;
  logic signed [31:0] last_q, last_d;
  logic               pos_valid_q, pos_valid_d;

  // latched command beat
  op_e                op_q, op_d;
  logic signed [27:0] tgt_q, tgt_d;
  logic signed [27:0] sen_q, sen_d;
  logic signed [31:0] enc_q, enc_d;

  // working registers
  logic signed [31:0] e_q, e_d;
  logic signed [31:0] de_q, de_d;
  logic signed [31:0] d2_q, d2_d;
  logic signed [63:0] sum_q, sum_d;
  logic signed [63:0] dterm_q, dterm_d;
  logic signed [32:0] err_q, err_d;
  logic signed [33:0] med_q, med_d;
  logic               far_q, far_d;
  logic               mid_q, mid_d;
  logic               nz_q, nz_d;
  logic signed [31:0] res_q, res_d;
  logic               direct_q, direct_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_data_q, out_data_d;

  // shared units
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic               div_start;
  cdiv_st_t           div_st;

  // combinational helpers
  logic signed [31:0] tgt_x, sen_x, s5, m5;
  logic signed [31:0] e_w;
  logic signed [32:0] err_w, mag_w;
  logic signed [63:0] clip_w;
  logic               in_fire;

  ipc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ipc_cdiv u_cdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_p),
    .stat_o     (div_st)
  );

  assign in_i.ready           = (state_q == ST_IDLE);
  assign in_fire              = in_i.valid && (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.drive_position = out_data_q;

  // positions scaled by 5 as shift and add
  assign tgt_x = 32'(tgt_q);
  assign sen_x = 32'(sen_q);
  assign s5    = (tgt_x <<< 2) + tgt_x;
  assign m5    = (sen_x <<< 2) + sen_x;
  assign e_w   = tgt_x - sen_x;

  // compensation distance to the stored position
  assign err_w = 33'(s5) - 33'(last_q);
  assign mag_w = err_w[32] ? -err_w : err_w;

  // derivative product clipped to +-2^52 before the times-250
  always_comb begin
    if (mul_p > KD_LIM_P) begin
      clip_w = KD_LIM_P;
    end else if (mul_p < KD_LIM_N) begin
      clip_w = KD_LIM_N;
    end else begin
      clip_w = mul_p;
    end
  end

  // multiplier operand select, one product per sequencer step
  always_comb begin
    case (state_q)
      ST_P_MI: begin
        mul_a = ki_q;
        mul_b = e_q;
      end
      ST_P_MP: begin
        mul_a = kp_q;
        mul_b = de_q;
      end
      ST_P_MD: begin
        mul_a = kd_q;
        mul_b = d2_q;
      end
      ST_C_MUL: begin
        mul_a = POINT_FOUR_Q16;
        mul_b = err_q[31:0];
      end
      default: begin
        mul_a = ki_q;
        mul_b = e_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    kp_d        = kp_q;
    ki_d        = ki_q;
    kd_d        = kd_q;
    e1_d        = e1_q;
    e2_d        = e2_q;
    acc_d       = acc_q;
    last_d      = last_q;
    pos_valid_d = pos_valid_q;
    op_d        = op_q;
    tgt_d       = tgt_q;
    sen_d       = sen_q;
    enc_d       = enc_q;
    e_d         = e_q;
    de_d        = de_q;
    d2_d        = d2_q;
    sum_d       = sum_q;
    dterm_d     = dterm_q;
    err_d       = err_q;
    med_d       = med_q;
    far_d       = far_q;
    mid_d       = mid_q;
    nz_d        = nz_q;
    res_d       = res_q;
    direct_d    = direct_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_o.ready;
    div_start   = 1'b0;

    // gain writes, which the user must issue only while idle; not enforced here
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_KP) begin
        kp_d = cfg_data_i;
      end
      if (cfg_idx_i == CFG_KI) begin
        ki_d = cfg_data_i;
      end
      if (cfg_idx_i == CFG_KD) begin
        kd_d = cfg_data_i;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d    = op_e'(in_i.operation);
          tgt_d   = in_i.target_position;
          sen_d   = in_i.sensed_position;
          enc_d   = in_i.motor_encoder;
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        direct_d = 1'b0;
        case (op_q)
          OP_PID: begin
            e_d     = e_w;
            de_d    = e_w - e1_q;
            d2_d    = e_w - (e1_q <<< 1) + e2_q;
            sum_d   = 64'(acc_q);
            state_d = ST_P_MI;
          end
          OP_COMP: begin
            if (!pos_valid_q) begin
              // first step only stores the scaled position and echoes the setpoint times 5
              last_d      = m5;
              pos_valid_d = 1'b1;
              res_d       = s5;
              direct_d    = 1'b1;
              state_d     = ST_EMIT;
            end else begin
              state_d = ST_C_BAND;
            end
          end
          OP_CLEAR: begin
            e1_d    = '0;
            e2_d    = '0;
            acc_d   = '0;
            state_d = ST_EMIT;
          end
          default: begin
            state_d = ST_EMIT;
          end
        endcase
      end

      // integral product issued here
      ST_P_MI: begin
        state_d = ST_P_MP;
      end

      // integral product goes to the divider, proportional issued
      ST_P_MP: begin
        div_start = 1'b1;
        state_d   = ST_P_MD;
      end

      // add proportional term, derivative issued
      ST_P_MD: begin
        sum_d   = sum_q + mul_p;
        state_d = ST_P_DSC;
      end

      // derivative term times 250 as 256 - 4 - 2
      ST_P_DSC: begin
        dterm_d = (clip_w <<< 8) - (clip_w <<< 2) - (clip_w <<< 1);
        state_d = ST_P_DADD;
      end

      ST_P_DADD: begin
        sum_d   = sum_q + dterm_q;
        state_d = ST_P_WAIT;
      end

      ST_P_WAIT: begin
        if (!div_st.busy) begin
          sum_d   = sum_q + div_st.quot;
          state_d = ST_P_SAT;
        end
      end

      ST_P_SAT: begin
        acc_d   = sat48(sum_q);
        e2_d    = e1_q;
        e1_d    = e_q;
        state_d = ST_EMIT;
      end

      // classify the distance, then the stored position moves on
      ST_C_BAND: begin
        err_d   = err_w;
        med_d   = 34'(s5) - 34'(last_q) + 34'(enc_q);
        far_d   = (mag_w >= FAR_BAND);
        mid_d   = (mag_w > NEAR_BAND);
        nz_d    = (err_w != 33'sd0);
        last_d  = m5;
        state_d = ST_C_MUL;
      end

      // 0.4 * error issued here
      ST_C_MUL: begin
        state_d = ST_C_UPD;
      end

      ST_C_UPD: begin
        if (far_q) begin
          acc_d = sat48(64'(s5) <<< 16);
        end else if (mid_q) begin
          acc_d = sat48(64'(med_q) <<< 16);
        end else if (nz_q) begin
          acc_d = sat48(64'(acc_q) + mul_p);
        end
        state_d = ST_EMIT;
      end

      // result into the output register once it is free
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = direct_q ? res_q : acc_out(acc_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      e1_q        <= '0;
      e2_q        <= '0;
      acc_q       <= '0;
      last_q      <= '0;
      pos_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kp_q        <= kp_d;
      ki_q        <= ki_d;
      kd_q        <= kd_d;
      e1_q        <= e1_d;
      e2_q        <= e2_d;
      acc_q       <= acc_d;
      last_q      <= last_d;
      pos_valid_q <= pos_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    tgt_q      <= tgt_d;
    sen_q      <= sen_d;
    enc_q      <= enc_d;
    e_q        <= e_d;
    de_q       <= de_d;
    d2_q       <= d2_d;
    sum_q      <= sum_d;
    dterm_q    <= dterm_d;
    err_q      <= err_d;
    med_q      <= med_d;
    far_q      <= far_d;
    mid_q      <= mid_d;
    nz_q       <= nz_d;
    res_q      <= res_d;
    direct_q   <= direct_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

/* hdl/ipc_checker.sv */
// ----------------------------------------------------------------------------
// ipc_checker
// port-level checks of the compensator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "incremental_pid_position_compensator_macros.svh"

module ipc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] drive_position_i
);

  // stalled result beat holds
  `IPC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(drive_position_i))

  // one command at a time
  `IPC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // no result in the cycle straight after a command beat
  `IPC_ASSERT_NEXT(a_no_instant_result, in_valid_i && in_ready_i, !$rose(out_valid_i))

  // returning to idle always leaves a result in the output register
  `IPC_ASSERT_SAME(a_idle_with_result, $rose(in_ready_i), out_valid_i)

endmodule

bind incremental_pid_position_compensator ipc_checker u_ipc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .drive_position_i (out_o.drive_position)
);

`default_nettype wire
